// ----- design/aes256_block_encrypt_core_defines.svh -----
// Assertion macros shared by the encryption core
`ifndef AES256_BLOCK_ENCRYPT_CORE_DEFINES_SVH
`define AES256_BLOCK_ENCRYPT_CORE_DEFINES_SVH

// Check that a condition implies a consequence on the next clock edge
`define AES_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence on the same clock edge
`define AES_ASSERT_NOW(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);

`endif

// ----- design/aes256_pkg.sv -----
`default_nettype none
package aes256_pkg;

    localparam int unsigned ROUNDS_DEFAULT = 10;

    typedef logic [127:0] block_t;
    typedef logic [255:0] key_t;

    // Control passed between cells
    typedef struct packed {
        logic valid;
    } cell_ctl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tab [256];
        tab = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tab[a];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // SubBytes and ShiftRows; byte 4c+r at bits 8*(4c+r)
    function automatic block_t sub_shift(input block_t s);
        block_t o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[8*(4*c+r) +: 8] = sbox(s[8*(4*((c+r)%4)+r) +: 8]);
            end
        end
        return o;
    endfunction

    function automatic block_t mix(input block_t s);
        block_t o;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = s[32*c +: 8];
            a1 = s[32*c+8 +: 8];
            a2 = s[32*c+16 +: 8];
            a3 = s[32*c+24 +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            o[32*c +: 8]    = a0 ^ al ^ xt(a0 ^ a1);
            o[32*c+8 +: 8]  = a1 ^ al ^ xt(a1 ^ a2);
            o[32*c+16 +: 8] = a2 ^ al ^ xt(a2 ^ a3);
            o[32*c+24 +: 8] = a3 ^ al ^ xt(a3 ^ a0);
        end
        return o;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Advance the key window by one round: words w..w+3 from the last eight
    // key: words 0..7 (word i at bits 32i); returns window shifted by four words
    function automatic key_t key_step(input key_t k, input logic even,
                                      input logic [7:0] rc);
        logic [31:0] w [8];
        logic [31:0] t;
        key_t o;
        for (int i = 0; i < 8; i++) begin
            w[i] = k[32*i +: 32];
        end
        t = w[7];
        if (even) begin
            t = sub_word({t[7:0], t[31:8]}) ^ {24'h0, rc};
        end else begin
            t = sub_word(t);
        end
        o[31:0]    = w[0] ^ t;
        o[63:32]   = w[1] ^ o[31:0];
        o[95:64]   = w[2] ^ o[63:32];
        o[127:96]  = w[3] ^ o[95:64];
        o[255:128] = o[127:0];
        o[127:0]   = k[255:128];
        return o;
    endfunction

    function automatic logic [7:0] rcon(input int unsigned n);
        logic [7:0] r;
        r = 8'h01;
        for (int i = 0; i < 8; i++) begin
            if (i < n) begin
                r = xt(r);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/aes256_round_cell.sv -----
`default_nettype none
// One round of the chain: cipher round plus one key schedule step
module aes256_round_cell
    import aes256_pkg::*;
#(
    parameter int unsigned RND = 1,
    parameter bit          LAST = 1'b0
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      adv,
    input  wire cell_ctl_t ctl_in,
    input  wire block_t    state_in,
    input  wire key_t      key_in,
    output cell_ctl_t      ctl_out,
    output block_t         state_out,
    output key_t           key_out
);
    // window holds round keys RND and RND+1; round key RND is the low half
    cell_ctl_t ctl_reg;
    block_t    state_reg, state_next;
    key_t      key_reg, key_next;
    block_t    ss;

    // Apply round and advance schedule by four words
    always_comb begin
        ss = sub_shift(state_in);
        if (!LAST) begin
            ss = mix(ss);
        end
        state_next = ss ^ key_in[255:128];
        key_next = key_step(key_in, (RND % 2) == 1, rcon((RND - 1) / 2));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;
endmodule
`default_nettype wire

// ----- design/aes256_block_encrypt_core.sv -----
`default_nettype none
// AES-256 style encryption, one block with its own 256-bit key per beat.
// A chain of ROUNDS round cells, each one cipher round and one key schedule
// step, plus a register for the initial key addition; a new beat is taken
// every cycle while the chain is not stalled. The whole chain stalls while
// the output beat waits; the front register is free when the chain moves.
`include "aes256_block_encrypt_core_defines.svh"
module aes256_block_encrypt_core
    import aes256_pkg::*;
#(
    parameter int unsigned ROUNDS = ROUNDS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_plain_lo,
    input  wire logic [63:0] s_plain_hi,
    input  wire logic [63:0] s_key_w0,
    input  wire logic [63:0] s_key_w1,
    input  wire logic [63:0] s_key_w2,
    input  wire logic [63:0] s_key_w3,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_cipher_lo,
    output logic [63:0]      m_cipher_hi
);
    cell_ctl_t ctl [ROUNDS+1];
    block_t    st  [ROUNDS+1];
    key_t      ky  [ROUNDS+1];
    logic      adv;
    cell_ctl_t ctl0_reg;
    block_t    st0_reg;
    key_t      ky0_reg;

    // Move the chain when the last stage is empty or being taken
    assign adv     = !ctl[ROUNDS].valid || m_ready;
    assign s_ready = adv;

    // Initial key addition
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl0_reg <= '0;
        end else if (adv) begin
            ctl0_reg.valid <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st0_reg <= {s_plain_hi, s_plain_lo} ^ {s_key_w1, s_key_w0};
            ky0_reg <= {s_key_w3, s_key_w2, s_key_w1, s_key_w0};
        end
    end

    assign ctl[0] = ctl0_reg;
    assign st[0]  = st0_reg;
    assign ky[0]  = ky0_reg;

    for (genvar g = 1; g <= ROUNDS; g++) begin : g_cell
        aes256_round_cell #(
            .RND  (g),
            .LAST (g == ROUNDS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .ctl_in    (ctl[g-1]),
            .state_in  (st[g-1]),
            .key_in    (ky[g-1]),
            .ctl_out   (ctl[g]),
            .state_out (st[g]),
            .key_out   (ky[g])
        );
    end

    assign m_valid     = ctl[ROUNDS].valid;
    assign m_cipher_lo = st[ROUNDS][63:0];
    assign m_cipher_hi = st[ROUNDS][127:64];

    // Stalled output holds, a stall blocks input, and an accepted beat enters the chain
    `AES_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
                     m_valid && $stable(m_cipher_lo) && $stable(m_cipher_hi),
                     "output beat changed while stalled")
    `AES_ASSERT_NOW(a_stall, aclk, aresetn, m_valid && !m_ready, !s_ready,
                    "input taken while output stalled")
    `AES_ASSERT_NEXT(a_enter, aclk, aresetn, s_valid && s_ready, ctl[0].valid,
                     "accepted beat did not enter the chain")
endmodule
`default_nettype wire

// ----- bench/aes256_block_encrypt_core_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module aes256_block_encrypt_core_tb;
    import aes256_pkg::*;

    localparam int unsigned NUM_ROUNDS = ROUNDS_DEFAULT;
    localparam int unsigned LATENCY = NUM_ROUNDS + 1;
    localparam int unsigned NUM_RANDOM = 1330;
    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned LONG_HOLD = 60;

    typedef struct packed {
        logic [63:0] plain_lo;
        logic [63:0] plain_hi;
        logic [63:0] key_w0;
        logic [63:0] key_w1;
        logic [63:0] key_w2;
        logic [63:0] key_w3;
    } block_item_t;

    typedef struct packed {
        logic [63:0] cipher_lo;
        logic [63:0] cipher_hi;
    } cipher_item_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_plain_lo, s_plain_hi, s_key_w0, s_key_w1, s_key_w2, s_key_w3;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_cipher_lo, m_cipher_hi;
    logic        s_ready_seen;

    block_item_t  pending_blocks[$];
    cipher_item_t expected_ciphers[$];

    int unsigned mismatch_count = 0;
    int unsigned accepted_in = 0;
    int unsigned accepted_out = 0;
    int unsigned idle_cycles = 0;
    logic        stim_done = 1'b0;
    logic        pause_until_drained = 1'b0;
    logic        hold_request = 1'b0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned long_hold_left = 0;

    aes256_block_encrypt_core #(.ROUNDS(NUM_ROUNDS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_plain_lo(s_plain_lo), .s_plain_hi(s_plain_hi),
        .s_key_w0(s_key_w0), .s_key_w1(s_key_w1),
        .s_key_w2(s_key_w2), .s_key_w3(s_key_w3),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_cipher_lo(m_cipher_lo), .m_cipher_hi(m_cipher_hi)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // S-box lookup, the table written out byte for byte
    function automatic logic [7:0] sbox_lookup(input logic [7:0] a);
        logic [7:0] tab [256];
        tab = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tab[a];
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Encrypt one block under its own key, byte arrays in column order
    function automatic cipher_item_t encrypt_block(input block_item_t it);
        logic [7:0] st [16];
        logic [7:0] nx [16];
        logic [7:0] sched [(NUM_ROUNDS + 1) * 16 + 32];
        logic [7:0] tw [4];
        logic [7:0] tmp, rc, a0, a1, a2, a3, all;
        cipher_item_t res;
        for (int i = 0; i < 8; i++) begin
            st[i]          = it.plain_lo[8*i +: 8];
            st[8+i]        = it.plain_hi[8*i +: 8];
            sched[i]       = it.key_w0[8*i +: 8];
            sched[8+i]     = it.key_w1[8*i +: 8];
            sched[16+i]    = it.key_w2[8*i +: 8];
            sched[24+i]    = it.key_w3[8*i +: 8];
        end
        rc = 8'h01;
        for (int w = 8; w < (NUM_ROUNDS + 1) * 4; w++) begin
            for (int b = 0; b < 4; b++) tw[b] = sched[(w-1)*4 + b];
            if ((w % 8) == 0) begin
                tmp = tw[0];
                tw[0] = sbox_lookup(tw[1]) ^ rc;
                tw[1] = sbox_lookup(tw[2]);
                tw[2] = sbox_lookup(tw[3]);
                tw[3] = sbox_lookup(tmp);
                rc = gf_double(rc);
            end else if ((w % 8) == 4) begin
                for (int b = 0; b < 4; b++) tw[b] = sbox_lookup(tw[b]);
            end
            for (int b = 0; b < 4; b++) sched[w*4 + b] = sched[(w-8)*4 + b] ^ tw[b];
        end
        for (int i = 0; i < 16; i++) st[i] ^= sched[i];
        for (int r = 1; r <= NUM_ROUNDS; r++) begin
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    nx[4*c + row] = sbox_lookup(st[4*((c + row) % 4) + row]);
            if (r < NUM_ROUNDS) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = nx[4*c]; a1 = nx[4*c+1]; a2 = nx[4*c+2]; a3 = nx[4*c+3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    nx[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
                    nx[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
                    nx[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
                    nx[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = nx[i] ^ sched[r*16 + i];
        end
        for (int i = 0; i < 8; i++) begin
            res.cipher_lo[8*i +: 8] = st[i];
            res.cipher_hi[8*i +: 8] = st[8+i];
        end
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Pick a field value: mostly random, sometimes an extreme, a single set bit or a single clear bit
    function automatic logic [63:0] pick_field();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0: return 64'h0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            3: return ~(64'h1 << $urandom_range(0, 63));
            default: return rand64();
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        if (sel < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Driver: hold the beat until taken, then load the next after a gap, waiting for the drain when paused
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready_seen)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pause_until_drained && expected_ciphers.size() != 0) begin
                s_valid <= 1'b0;
            end else if (pending_blocks.size() != 0) begin
                block_item_t nxt;
                nxt = pending_blocks.pop_front();
                s_plain_lo <= nxt.plain_lo;
                s_plain_hi <= nxt.plain_hi;
                s_key_w0 <= nxt.key_w0;
                s_key_w1 <= nxt.key_w1;
                s_key_w2 <= nxt.key_w2;
                s_key_w3 <= nxt.key_w3;
                s_valid <= 1'b1;
                send_gap <= long_hold_left > 0 ? 0 : pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Track whether the current beat is still waiting at the falling edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_ready_seen <= 1'b1;
        end else begin
            s_ready_seen <= s_valid && s_ready;
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request && long_hold_left == 0 && m_ready) begin
            long_hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (long_hold_left > 0) begin
            long_hold_left <= long_hold_left - 1;
            m_ready <= (long_hold_left == 1);
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            recv_gap <= pick_gap();
        end
    end

    // Predict on input beats, check output beats, run the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_ciphers.push_back(encrypt_block({s_plain_lo, s_plain_hi,
                    s_key_w0, s_key_w1, s_key_w2, s_key_w3}));
                accepted_in++;
            end
            if (m_valid && m_ready) begin
                accepted_out++;
                if (expected_ciphers.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat: lo=%h hi=%h", m_cipher_lo, m_cipher_hi);
                end else begin
                    cipher_item_t exp_c;
                    exp_c = expected_ciphers.pop_front();
                    if (exp_c.cipher_lo !== m_cipher_lo || exp_c.cipher_hi !== m_cipher_hi) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch beat %0d: exp lo=%h hi=%h got lo=%h hi=%h",
                                     accepted_out, exp_c.cipher_lo, exp_c.cipher_hi,
                                     m_cipher_lo, m_cipher_hi);
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                    $display("watchdog expired: in=%0d out=%0d", accepted_in, accepted_out);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    task automatic queue_block(input logic [63:0] p0, input logic [63:0] p1,
                               input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3);
        pending_blocks.push_back({p0, p1, k0, k1, k2, k3});
    endtask

    task automatic wait_drained();
        while (pending_blocks.size() != 0 || s_valid || expected_ciphers.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_plain_lo = '0; s_plain_hi = '0;
        s_key_w0 = '0; s_key_w1 = '0; s_key_w2 = '0; s_key_w3 = '0;
        repeat (2) @(posedge aclk);
        #1 aresetn = 1'b1;

        // Directed: extremes, walking bits, and a known test key pattern
        queue_block(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
        queue_block('1, '1, '1, '1, '1, '1);
        queue_block(64'h0, 64'h0, '1, '1, '1, '1);
        queue_block('1, '1, 64'h0, 64'h0, 64'h0, 64'h0);
        queue_block(64'h7766554433221100, 64'hffeeddccbbaa9988,
                    64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                    64'h1716151413121110, 64'h1f1e1d1c1b1a1918);
        queue_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
                    64'haaaaaaaaaaaaaaaa, 64'h5555555555555555,
                    64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        queue_block(64'h1, 64'h8000000000000000, 64'h1, 64'h0, 64'h0, 64'h8000000000000000);
        for (int i = 0; i < 8; i++)
            queue_block(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 64'hff << (8 * i));
        for (int i = 0; i < 6; i++)
            queue_block(64'h1 << (i * 11), 64'h0, 64'h0, 64'h1 << (i * 9), 64'h0, 64'h0);
        wait_drained();

        // Sender pause: every expected result arrives before the next beat
        pause_until_drained = 1'b1;
        for (int i = 0; i < 3; i++)
            queue_block(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
        wait_drained();
        pause_until_drained = 1'b0;

        // Random blocks, with a long receiver hold-off partway through
        for (int i = 0; i < NUM_RANDOM; i++) begin
            queue_block(pick_field(), pick_field(), pick_field(),
                        pick_field(), pick_field(), pick_field());
        end
        while (pending_blocks.size() > NUM_RANDOM / 2) @(posedge aclk);
        hold_request = 1'b1;
        @(posedge aclk);
        while (long_hold_left == 0) @(posedge aclk);
        hold_request = 1'b0;
        wait_drained();
        repeat (LATENCY + 4) @(posedge aclk);

        $display("covered %0d blocks in, %0d ciphertexts out, rounds=%0d, with stalls",
                 accepted_in, accepted_out, NUM_ROUNDS);
        if (mismatch_count == 0 && expected_ciphers.size() == 0) begin
            $display("PASS");
        end else begin
            $display("mismatches: %0d, left over: %0d", mismatch_count, expected_ciphers.size());
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
